FILE: design/asds_pkg.sv
// Shared types, constants and tables for the ADC sample duration select unit.
// Used by asds_ctrl, asds_dpath and adc_sample_duration_select_unit; no dependencies.
`default_nettype none
package asds_pkg;

  localparam longint unsigned CLOCK_HZ = 64'd48000000;
  localparam int CHANNEL_COUNT = 16;
  localparam logic [15:0] CYCLE_LIMIT = 16'd1023;

  localparam int DIV_COUNT = 8;
  localparam int DIV_IDX_W = $clog2(DIV_COUNT);
  localparam logic [5:0] DIV_TABLE [DIV_COUNT] = '{
    6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd24, 6'd32, 6'd48
  };
  localparam logic [DIV_IDX_W-1:0] CODE_DEFAULT = DIV_IDX_W'(DIV_COUNT - 1);
  localparam logic [DIV_IDX_W-1:0] CODE_TICKS = '0;

  localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  // Divided clock period in ns, unsigned Q16, truncated
  function automatic longint unsigned period_f(int idx);
    return (64'd1000000000 * 64'(DIV_TABLE[idx]) * 64'd65536) / CLOCK_HZ;
  endfunction

  localparam int PER_W = $clog2(period_f(DIV_COUNT - 1) + 1);
  localparam logic [PER_W-1:0] PERIOD_Q16 [DIV_COUNT] = '{
    PER_W'(period_f(0)), PER_W'(period_f(1)), PER_W'(period_f(2)), PER_W'(period_f(3)),
    PER_W'(period_f(4)), PER_W'(period_f(5)), PER_W'(period_f(6)), PER_W'(period_f(7))
  };

  // Target in ns: at most 16383 us
  localparam int TGT_W = $clog2(16383 * 1000 + 1);
  localparam int NUM_W = ((TGT_W + 16 > PER_W) ? TGT_W + 16 : PER_W) + 1;
  localparam int PROD_W = PER_W + 16;

  // Quotient bits resolved per divider step
  localparam int RADIX_BITS = 2;
  localparam int DIV_STEPS = 16 / RADIX_BITS;
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic [1:0] REF_INVALID = 2'd3;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_BAD_CHAN = 3'd1,
    STS_DIFF     = 3'd2,
    STS_GAIN     = 3'd3,
    STS_REF      = 3'd4,
    STS_NO_CLK   = 3'd5,
    STS_MISMATCH = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    UNIT_DEFAULT = 2'd0,
    UNIT_US      = 2'd1,
    UNIT_NS      = 2'd2,
    UNIT_TICKS   = 2'd3
  } unit_e;

  typedef struct packed {
    logic                 capture;
    logic                 ref_wr;
    logic                 search_init;
    logic                 load;
    logic                 div_step;
    logic                 mul;
    logic                 cmp;
    logic                 finish;
    logic [DIV_IDX_W-1:0] div_idx;
  } cmd_t;

  typedef struct packed {
    logic chk_err;
    logic unit_search;
  } sts_t;

endpackage
`default_nettype wire

FILE: design/asds_ctrl.sv
// Sequencer for the sample duration select unit: request checks and the divider search.
// Depends on asds_pkg.
`default_nettype none
module asds_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  asds_pkg::sts_t   sts_i,
  output asds_pkg::cmd_t   cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CHECK  = 7'b0000010,
    ST_LOAD   = 7'b0000100,
    ST_DIV    = 7'b0001000,
    ST_MUL    = 7'b0010000,
    ST_CMP    = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  state_e                         state_q, state_d;
  logic [asds_pkg::STEP_W-1:0]    step_q, step_d;
  logic [asds_pkg::DIV_IDX_W-1:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.chk_err) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.ref_wr = 1'b1;
          if (sts_i.unit_search) begin
            cmd_o.search_init = 1'b1;
            idx_d             = '0;
            state_d           = ST_LOAD;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        step_d     = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == asds_pkg::STEP_W'(asds_pkg::DIV_STEPS - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        if (idx_q == asds_pkg::DIV_IDX_W'(asds_pkg::DIV_COUNT - 1)) begin
          state_d = ST_FINISH;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    cmd_o.div_idx = idx_q;
  end

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/asds_dpath.sv
// Datapath: captured request, reference store, shared radix-4 divider, multiplier,
// best-candidate tracking, cycle latch and result registers. Depends on asds_pkg.
`default_nettype none
module asds_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  asds_pkg::cmd_t                   cmd_i,
  output asds_pkg::sts_t                   sts_o,
  input  logic [7:0]                       channel_number_i,
  input  logic                             is_differential_i,
  input  logic                             gain_is_unity_i,
  input  logic [1:0]                       reference_choice_i,
  input  logic [1:0]                       time_unit_i,
  input  logic [13:0]                      time_value_i,
  output logic                             done_o,
  output logic [2:0]                       status_o,
  output logic [5:0]                       divider_value_o,
  output logic [2:0]                       divider_code_o,
  output logic [15:0]                      sample_cycles_o
);

  localparam int PER_W  = asds_pkg::PER_W;
  localparam int NUM_W  = asds_pkg::NUM_W;
  localparam int TGT_W  = asds_pkg::TGT_W;
  localparam int PROD_W = asds_pkg::PROD_W;
  localparam int IDX_W  = asds_pkg::DIV_IDX_W;

  // Captured request
  logic [7:0]        chan_q;
  logic              diff_q;
  logic              unity_q;
  logic [1:0]        ref_q;
  asds_pkg::unit_e   unit_q;
  logic [13:0]       val_q;

  logic [1:0] ref_mem [asds_pkg::CHANNEL_COUNT];

  // Search state
  logic [TGT_W-1:0]  target_q;
  logic [PER_W-1:0]  rem_q, rem_d;
  logic [15:0]       lo_q, lo_d;
  logic [15:0]       quot_q, quot_d;
  logic              sat_q;
  logic [15:0]       c_q;
  logic [PROD_W-1:0] prod_q;
  logic [15:0]       best_c_q;
  logic [31:0]       best_delta_q;
  logic [IDX_W-1:0]  best_code_q;
  logic              found_q;

  // Cycle latch
  logic [5:0]        lat_div_q;
  logic [15:0]       lat_cyc_q;

  // Result registers
  logic              done_q;
  asds_pkg::status_e status_q;
  logic [5:0]        divv_q;
  logic [2:0]        code_q;
  logic [15:0]       cyc_q;

  asds_pkg::status_e pre_status;
  logic [PER_W-1:0]  per;
  logic [NUM_W-1:0]  num;
  logic              sat_n;
  logic [15:0]       c_n;
  logic [PER_W-1:0]  dur;
  logic [31:0]       delta;
  logic              take;

  asds_pkg::status_e fin_status;
  logic [IDX_W-1:0]  fin_code;
  logic [15:0]       fin_cyc;
  logic [5:0]        fin_div;

  // Request checks in priority order
  always_comb begin
    if (chan_q > 8'(asds_pkg::CHANNEL_COUNT - 1)) begin
      pre_status = asds_pkg::STS_BAD_CHAN;
    end else if (diff_q) begin
      pre_status = asds_pkg::STS_DIFF;
    end else if (!unity_q) begin
      pre_status = asds_pkg::STS_GAIN;
    end else if (ref_q == asds_pkg::REF_INVALID) begin
      pre_status = asds_pkg::STS_REF;
    end else begin
      pre_status = asds_pkg::STS_OK;
    end
  end

  assign sts_o.chk_err     = (pre_status != asds_pkg::STS_OK);
  assign sts_o.unit_search = (unit_q == asds_pkg::UNIT_US) || (unit_q == asds_pkg::UNIT_NS);

  assign per = asds_pkg::PERIOD_Q16[cmd_i.div_idx];

  // Rounded-up numerator: T*2^16 + P - 2^16 (P is always above 2^16)
  assign num   = NUM_W'({target_q, 16'h0000}) + NUM_W'(per) - NUM_W'(32'h0001_0000);
  // Quotient above 16 bits saturates
  assign sat_n = (NUM_W'(num[NUM_W-1:16]) >= NUM_W'(per));

  // Restoring divider, RADIX_BITS quotient bits per step
  always_comb begin
    logic [PER_W:0] t;
    logic [PER_W-1:0] r;
    logic [15:0] q;
    logic [15:0] lo;
    r  = rem_q;
    q  = quot_q;
    lo = lo_q;
    for (int k = 0; k < asds_pkg::RADIX_BITS; k++) begin
      t  = {r, lo[15]};
      lo = {lo[14:0], 1'b0};
      if (t >= {1'b0, per}) begin
        t = t - {1'b0, per};
        q = {q[14:0], 1'b1};
      end else begin
        q = {q[14:0], 1'b0};
      end
      r = t[PER_W-1:0];
    end
    rem_d  = r;
    quot_d = q;
    lo_d   = lo;
  end

  assign c_n   = sat_q ? 16'hFFFF : quot_q;
  assign dur   = prod_q[PROD_W-1:16];
  assign delta = 32'(dur) - 32'(target_q);
  assign take  = (c_q <= best_c_q) && (delta <= best_delta_q);

  // Final selection and latch comparison
  always_comb begin
    fin_status = pre_status;
    fin_code   = '0;
    fin_cyc    = '0;
    if (pre_status == asds_pkg::STS_OK) begin
      case (unit_q)
        asds_pkg::UNIT_TICKS: begin
          fin_code = asds_pkg::CODE_TICKS;
          fin_cyc  = 16'(val_q);
        end
        asds_pkg::UNIT_US, asds_pkg::UNIT_NS: begin
          if (found_q) begin
            fin_code = best_code_q;
            fin_cyc  = best_c_q;
          end else begin
            fin_status = asds_pkg::STS_NO_CLK;
          end
        end
        default: begin
          fin_code = asds_pkg::CODE_DEFAULT;
          fin_cyc  = 16'd1;
        end
      endcase
    end
    fin_div = asds_pkg::DIV_TABLE[fin_code];
    if (fin_status == asds_pkg::STS_OK && lat_cyc_q != '0 &&
        (fin_div != lat_div_q || fin_cyc != lat_cyc_q)) begin
      fin_status = asds_pkg::STS_MISMATCH;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      chan_q  <= channel_number_i;
      diff_q  <= is_differential_i;
      unity_q <= gain_is_unity_i;
      ref_q   <= reference_choice_i;
      unit_q  <= asds_pkg::unit_e'(time_unit_i);
      val_q   <= time_value_i;
    end
    if (cmd_i.ref_wr) begin
      ref_mem[chan_q[asds_pkg::CH_IDX_W-1:0]] <= ref_q;
    end
    if (cmd_i.search_init) begin
      target_q     <= (unit_q == asds_pkg::UNIT_US) ?
                      TGT_W'(TGT_W'(val_q) * TGT_W'(1000)) : TGT_W'(val_q);
      best_c_q     <= asds_pkg::CYCLE_LIMIT;
      best_delta_q <= 32'hFFFF_FFFF;
      best_code_q  <= '0;
      found_q      <= 1'b0;
    end
    if (cmd_i.load) begin
      sat_q  <= sat_n;
      rem_q  <= PER_W'(num[NUM_W-1:16]);
      lo_q   <= num[15:0];
      quot_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= rem_d;
      lo_q   <= lo_d;
      quot_q <= quot_d;
    end
    if (cmd_i.mul) begin
      c_q    <= c_n;
      prod_q <= PROD_W'(per) * PROD_W'(c_n);
    end
    if (cmd_i.cmp && take) begin
      best_c_q     <= c_q;
      best_delta_q <= delta;
      best_code_q  <= cmd_i.div_idx;
      found_q      <= 1'b1;
    end
    if (cmd_i.finish) begin
      status_q <= fin_status;
      if (fin_status == asds_pkg::STS_OK) begin
        divv_q <= fin_div;
        code_q <= 3'(fin_code);
        cyc_q  <= fin_cyc;
      end else begin
        divv_q <= '0;
        code_q <= '0;
        cyc_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      lat_div_q <= '0;
      lat_cyc_q <= '0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.finish && fin_status == asds_pkg::STS_OK && lat_cyc_q == '0) begin
        lat_div_q <= fin_div;
        lat_cyc_q <= fin_cyc;
      end
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign divider_value_o = divv_q;
  assign divider_code_o  = code_q;
  assign sample_cycles_o = cyc_q;

endmodule
`default_nettype wire

FILE: design/adc_sample_duration_select_unit.sv
// Sequence: a request accepted on start runs CHECK then FINISH for tick, default or
// rejected requests, and CHECK, the divider search, then FINISH for us/ns requests.
// The us/ns search covers 8 dividers on one shared divider: load, divide steps, multiply
// and compare for each. done_o is registered from FINISH; start is taken again as done_o
// rises. Reset (rst_ni, async low) returns to idle and clears the cycle latch; done_o is
// a one-cycle strobe and the receiver cannot stall it.
`default_nettype none
module adc_sample_duration_select_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  channel_number_i,
  input  logic        is_differential_i,
  input  logic        gain_is_unity_i,
  input  logic [1:0]  reference_choice_i,
  input  logic [1:0]  time_unit_i,
  input  logic [13:0] time_value_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [5:0]  divider_value_o,
  output logic [2:0]  divider_code_o,
  output logic [15:0] sample_cycles_o
);

  // Controller to datapath commands and back
  asds_pkg::cmd_t cmd;
  asds_pkg::sts_t sts;

  // Sequencer: check, then per divider load / 8 divide steps / multiply / compare
  asds_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Datapath: request registers, reference store, divider search, latch, result regs
  asds_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .channel_number_i   (channel_number_i),
    .is_differential_i  (is_differential_i),
    .gain_is_unity_i    (gain_is_unity_i),
    .reference_choice_i (reference_choice_i),
    .time_unit_i        (time_unit_i),
    .time_value_i       (time_value_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .divider_value_o    (divider_value_o),
    .divider_code_o     (divider_code_o),
    .sample_cycles_o    (sample_cycles_o)
  );

`ifndef SYNTH
  // A finishing request always produces a result strobe next cycle
  a_finish_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> done_o)
    else $error("finish without result strobe");

  // Result strobe only ever follows the finish step
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cmd.finish))
    else $error("result strobe without finish");

  // Rejected requests carry zeroed result fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != asds_pkg::STS_OK) |->
      (divider_value_o == '0 && divider_code_o == '0 && sample_cycles_o == '0))
    else $error("nonzero fields on error status");

  // An accepted request makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not start");
`endif

endmodule
`default_nettype wire
